### rtl/core/vfcm_pkg.sv
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared widths, codes and controller/datapath link types for the voxel
// face culling mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

	localparam int W_POS  = 4;
	localparam int W_COL  = 8;
	localparam int W_DIM  = 5;
	localparam int W_DIR  = 3;
	localparam int W_CFGA = 2;
	localparam int N_FACE = 6;

	localparam logic [W_DIM-1:0] DIM_RESET = 5'd16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_MESH  = 1'b1;

	localparam logic [W_CFGA-1:0] CFG_DIM_X = 2'd0;
	localparam logic [W_CFGA-1:0] CFG_DIM_Y = 2'd1;
	localparam logic [W_CFGA-1:0] CFG_DIM_Z = 2'd2;

	// scan steps: centre voxel, then the six neighbours in face order
	localparam logic [2:0] STEP_CENTRE = 3'd0;
	localparam logic [2:0] STEP_FRONT  = 3'd1;
	localparam logic [2:0] STEP_LEFT   = 3'd2;
	localparam logic [2:0] STEP_RIGHT  = 3'd3;
	localparam logic [2:0] STEP_BACK   = 3'd4;
	localparam logic [2:0] STEP_TOP    = 3'd5;
	localparam logic [2:0] STEP_BOTTOM = 3'd6;
	localparam logic [2:0] STEP_END    = 3'd7;

	localparam logic [W_DIR-1:0] DIR_NONE = 3'd0;

	typedef enum logic [1:0] {
		KIND_ACK    = 2'd0,
		KIND_FACE   = 2'd1,
		KIND_NOFACE = 2'd2
	} kind_t;

	typedef struct packed {
		logic             opcode;
		logic [W_POS-1:0] pos_x;
		logic [W_POS-1:0] pos_y;
		logic [W_POS-1:0] pos_z;
		logic             occupied;
		logic [W_COL-1:0] red;
		logic [W_COL-1:0] green;
		logic [W_COL-1:0] blue;
		logic [W_COL-1:0] alpha;
	} item_t;

	typedef struct packed {
		kind_t            kind;
		logic             error;
		logic [W_POS-1:0] face_x;
		logic [W_POS-1:0] face_y;
		logic [W_POS-1:0] face_z;
		logic [W_DIR-1:0] face_dir;
		logic [W_COL-1:0] red;
		logic [W_COL-1:0] green;
		logic [W_COL-1:0] blue;
		logic [W_COL-1:0] alpha;
		logic             last;
	} res_t;

	typedef struct packed {
		logic       clr;
		logic       load_item;
		logic       mem_write;
		logic       scan_rd;
		logic [2:0] step;
		logic       out_load;
		kind_t      out_sel;
	} cmd_t;

	typedef struct packed {
		logic faces;
		logic last_face;
	} sts_t;

endpackage

### rtl/core/vfcm_ifs.sv
// ----------------------------------------------------------------------------
// vfcm interfaces
// Valid/ready channels: item input, result output, configuration writes.
// ----------------------------------------------------------------------------
interface vfcm_item_if;
	import vfcm_pkg::*;
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [W_POS-1:0] pos_x;
	logic [W_POS-1:0] pos_y;
	logic [W_POS-1:0] pos_z;
	logic             occupied;
	logic [W_COL-1:0] red_in;
	logic [W_COL-1:0] green_in;
	logic [W_COL-1:0] blue_in;
	logic [W_COL-1:0] alpha_in;

	modport source (output valid, opcode, pos_x, pos_y, pos_z, occupied,
		red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, opcode, pos_x, pos_y, pos_z, occupied,
		red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface vfcm_res_if;
	import vfcm_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic             error;
	logic [W_POS-1:0] face_x;
	logic [W_POS-1:0] face_y;
	logic [W_POS-1:0] face_z;
	logic [W_DIR-1:0] face_dir;
	logic [W_COL-1:0] red_out;
	logic [W_COL-1:0] green_out;
	logic [W_COL-1:0] blue_out;
	logic [W_COL-1:0] alpha_out;
	logic             last;

	modport source (output valid, kind, error, face_x, face_y, face_z, face_dir,
		red_out, green_out, blue_out, alpha_out, last, input ready);
	modport sink (input valid, kind, error, face_x, face_y, face_z, face_dir,
		red_out, green_out, blue_out, alpha_out, last, output ready);
endinterface

interface vfcm_cfg_if;
	import vfcm_pkg::*;
	logic              valid;
	logic              ready;
	logic [W_CFGA-1:0] addr;
	logic [W_DIM-1:0]  data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

### rtl/core/vfcm_ctrl.sv
// ----------------------------------------------------------------------------
// vfcm_ctrl
// Sequencer: store clear after reset, write, seven-read scan, record issue.
// ----------------------------------------------------------------------------
module vfcm_ctrl #(
	parameter int MAX_DIM = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_opcode,
	output logic            item_ready,
	output logic            res_valid,
	input  logic            res_ready,
	input  vfcm_pkg::sts_t  sts,
	output vfcm_pkg::cmd_t  cmd,
	output logic [$clog2(MAX_DIM*MAX_DIM*MAX_DIM)-1:0] clr_addr
);
	import vfcm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WRITE,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_cnt_q;
	logic [2:0]    step_q;
	logic          out_vld_q;
	logic          can_load;
	logic          accept;

	assign can_load   = !out_vld_q || res_ready;
	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign res_valid  = out_vld_q;
	assign clr_addr   = clr_cnt_q;

	always_comb begin
		cmd = '0;
		cmd.out_sel = KIND_ACK;
		cmd.step = STEP_CENTRE;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
			end
			S_IDLE: begin
				cmd.load_item = accept;
			end
			S_WRITE: begin
				// rewrite while the ack waits is harmless
				cmd.mem_write = 1'b1;
				cmd.out_load  = can_load;
			end
			S_SCAN: begin
				cmd.scan_rd = (step_q != STEP_END);
				cmd.step    = step_q;
			end
			S_EMIT: begin
				cmd.out_load = can_load;
				cmd.out_sel  = sts.faces ? KIND_FACE : KIND_NOFACE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			step_q    <= STEP_CENTRE;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (res_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						step_q  <= STEP_CENTRE;
						state_q <= (item_opcode == OP_MESH) ? S_SCAN : S_WRITE;
					end
				end
				S_WRITE: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_END) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_load && (!sts.faces || sts.last_face)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/vfcm_dp.sv
// ----------------------------------------------------------------------------
// vfcm_dp
// Datapath: dimension registers, item register, voxel store, neighbour
// addressing, exposed-face mask and result register.
// ----------------------------------------------------------------------------
module vfcm_dp #(
	parameter int MAX_DIM = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vfcm_pkg::cmd_t              cmd,
	input  logic [$clog2(MAX_DIM*MAX_DIM*MAX_DIM)-1:0] clr_addr,
	input  vfcm_pkg::item_t             item_pl,
	input  logic                        cfg_valid,
	input  logic [vfcm_pkg::W_CFGA-1:0] cfg_addr,
	input  logic [vfcm_pkg::W_DIM-1:0]  cfg_data,
	output vfcm_pkg::sts_t              sts,
	output vfcm_pkg::res_t              res_pl
);
	import vfcm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	logic [W_DIM-1:0]  dim_x_q, dim_y_q, dim_z_q;
	logic [W_DIM-1:0]  eff_x, eff_y, eff_z;
	item_t             item_q;
	logic              ok;

	logic [W_DIM-1:0]  nx, ny, nz;
	logic              under;
	logic              nb_in;
	logic [AW-1:0]     nb_addr;

	logic [32:0]       mem [DEPTH];
	logic              we;
	logic [AW-1:0]     addr;
	logic [32:0]       wdata;

	logic [32:0]       rd_data_s1;
	logic              rd_vld_s1;
	logic [2:0]        rd_idx_s1;
	logic              rd_in_s1;
	logic              rd_solid;

	logic              centre_solid_q;
	logic [31:0]       colour_q;
	logic [N_FACE-1:0] mask_q;
	logic [N_FACE-1:0] mask_next;
	logic [W_DIR-1:0]  first;
	res_t              res_q;

	// dimension registers; eff_x/y/z clamp them to the store size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= DIM_RESET;
			dim_y_q <= DIM_RESET;
			dim_z_q <= DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_addr)
				CFG_DIM_X: dim_x_q <= cfg_data;
				CFG_DIM_Y: dim_y_q <= cfg_data;
				CFG_DIM_Z: dim_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_x = (32'(dim_x_q) > MAX_DIM) ? W_DIM'(MAX_DIM) : dim_x_q;
	assign eff_y = (32'(dim_y_q) > MAX_DIM) ? W_DIM'(MAX_DIM) : dim_y_q;
	assign eff_z = (32'(dim_z_q) > MAX_DIM) ? W_DIM'(MAX_DIM) : dim_z_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item_pl;
		end
	end

	assign ok = ({1'b0, item_q.pos_x} < eff_x) && ({1'b0, item_q.pos_y} < eff_y) &&
		({1'b0, item_q.pos_z} < eff_z);

	// neighbour position for the current scan step; under marks a step below 0
	always_comb begin
		under = 1'b0;
		nx = {1'b0, item_q.pos_x};
		ny = {1'b0, item_q.pos_y};
		nz = {1'b0, item_q.pos_z};
		case (cmd.step)
			STEP_FRONT: begin
				under = (item_q.pos_z == '0);
				nz = nz - 1'b1;
			end
			STEP_LEFT: begin
				under = (item_q.pos_x == '0);
				nx = nx - 1'b1;
			end
			STEP_RIGHT: begin
				nx = nx + 1'b1;
			end
			STEP_BACK: begin
				nz = nz + 1'b1;
			end
			STEP_TOP: begin
				under = (item_q.pos_y == '0);
				ny = ny - 1'b1;
			end
			STEP_BOTTOM: begin
				ny = ny + 1'b1;
			end
			default: ;
		endcase
	end

	assign nb_in   = !under && (nx < eff_x) && (ny < eff_y) && (nz < eff_z);
	assign nb_addr = AW'(nx) + AW'(ny) * AW'(MAX_DIM) + AW'(nz) * AW'(MAX_DIM * MAX_DIM);

	// single-port voxel store: {occupied, R, G, B, A}
	assign we    = cmd.clr || (cmd.mem_write && ok);
	assign addr  = cmd.clr ? clr_addr : nb_addr;
	assign wdata = cmd.clr ? '0 : {item_q.occupied, item_q.red, item_q.green,
		item_q.blue, item_q.alpha};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd_idx_s1 <= cmd.step;
			rd_in_s1  <= nb_in;
		end
	end

	assign rd_solid = rd_in_s1 && rd_data_s1[32];

	// lowest pending face goes first
	always_comb begin
		first = DIR_NONE;
		for (int i = N_FACE - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				first = W_DIR'(i);
			end
		end
	end

	assign mask_next     = mask_q & ~(N_FACE'(1) << first);
	assign sts.faces     = centre_solid_q && (mask_q != '0);
	assign sts.last_face = (mask_next == '0);

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_idx_s1 == STEP_CENTRE) begin
				centre_solid_q <= rd_solid;
				colour_q       <= rd_data_s1[31:0];
			end else begin
				mask_q[rd_idx_s1 - 3'd1] <= !rd_solid;
			end
		end else if (cmd.out_load && cmd.out_sel == KIND_FACE) begin
			mask_q <= mask_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.kind   <= cmd.out_sel;
			res_q.face_x <= item_q.pos_x;
			res_q.face_y <= item_q.pos_y;
			res_q.face_z <= item_q.pos_z;
			if (cmd.out_sel == KIND_FACE) begin
				res_q.error    <= 1'b0;
				res_q.face_dir <= first;
				res_q.red      <= colour_q[31:24];
				res_q.green    <= colour_q[23:16];
				res_q.blue     <= colour_q[15:8];
				res_q.alpha    <= colour_q[7:0];
				res_q.last     <= (mask_next == '0);
			end else begin
				res_q.error    <= !ok;
				res_q.face_dir <= DIR_NONE;
				res_q.red      <= '0;
				res_q.green    <= '0;
				res_q.blue     <= '0;
				res_q.alpha    <= '0;
				res_q.last     <= 1'b1;
			end
		end
	end

	assign res_pl = res_q;

endmodule

### rtl/core/voxel_face_culling_mesher_top.sv
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_top
// Voxel grid store with exposed-face culling and per-face record output.
// ----------------------------------------------------------------------------
// Usage:
//  item   : valid/ready request in. opcode write stores one voxel at
//           (pos_x, pos_y, pos_z); opcode mesh asks for that voxel's faces.
//  result : valid/ready request out. A write gives one ack; a mesh gives one
//           face record per exposed face (front, left, right, back, top,
//           bottom), or a single no-face record. last marks the final one.
//  cfg    : dim_x/dim_y/dim_z writes, always ready; write only while idle.
// Flow: one item in flight. A write puts its ack in the output register from
//  the write state once that register is free. A mesh does 7 single-port
//  store reads (centre plus six neighbours), then issues one record a cycle
//  while the result register can take it.
// Reset: the store is swept to empty, one entry a cycle, all MAX_DIM^3 entries
//  (4096 at the default); item.ready stays low until the sweep ends.
// Stall: the result register holds while result.ready is low; the
//  sequencer waits, and the next item may be taken once the last record
//  sits in the result register.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher_top #(
	parameter int MAX_DIM = 16
) (
	input logic          clk,
	input logic          arst_n,
	vfcm_item_if.sink    item,
	vfcm_res_if.source   result,
	vfcm_cfg_if.sink     cfg
);
	import vfcm_pkg::*;

	localparam int AW = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);

	cmd_t          cmd;
	sts_t          sts;
	item_t         item_pl;
	res_t          res_pl;
	logic [AW-1:0] clr_addr;

	// configuration never back-pressures
	assign cfg.ready = 1'b1;

	assign item_pl = '{
		opcode:   item.opcode,
		pos_x:    item.pos_x,
		pos_y:    item.pos_y,
		pos_z:    item.pos_z,
		occupied: item.occupied,
		red:      item.red_in,
		green:    item.green_in,
		blue:     item.blue_in,
		alpha:    item.alpha_in
	};

	// sequencer
	vfcm_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_opcode (item.opcode),
		.item_ready  (item.ready),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.sts         (sts),
		.cmd         (cmd),
		.clr_addr    (clr_addr)
	);

	// store, neighbour check and result register
	vfcm_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.clr_addr  (clr_addr),
		.item_pl   (item_pl),
		.cfg_valid (cfg.valid),
		.cfg_addr  (cfg.addr),
		.cfg_data  (cfg.data),
		.sts       (sts),
		.res_pl    (res_pl)
	);

	assign result.kind      = res_pl.kind;
	assign result.error     = res_pl.error;
	assign result.face_x    = res_pl.face_x;
	assign result.face_y    = res_pl.face_y;
	assign result.face_z    = res_pl.face_z;
	assign result.face_dir  = res_pl.face_dir;
	assign result.red_out   = res_pl.red;
	assign result.green_out = res_pl.green;
	assign result.blue_out  = res_pl.blue;
	assign result.alpha_out = res_pl.alpha;
	assign result.last      = res_pl.last;

	// one item at a time: no request taken straight after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item accepted while previous one in progress");

	// a face only exists for an in-grid voxel
	a_face_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == KIND_FACE |-> !result.error)
		else $error("face record flagged out of range");

	// acks and no-face records are always single
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind != KIND_FACE |-> result.last)
		else $error("single record without last");

	// the store clear is a write-only sweep: no read or item load overlaps it
	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !cmd.scan_rd && !cmd.load_item && !item.ready)
		else $error("activity during store clear");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the voxel face culling mesher. A behavioural copy
// of the voxel store predicts every ack, face and no-face record. Directed
// cases come first, then clustered random traffic under three grid sizes
// and idling mixes, then a long result stall that backs up the item port.
// ----------------------------------------------------------------------------
module tb;
	import vfcm_pkg::*;

	localparam int GRID_MAX      = 16;
	localparam int STORE_SLOTS   = GRID_MAX * GRID_MAX * GRID_MAX;
	// watchdog limit lies above the reset sweep and the long stall (HOLD_CYCLES)
	localparam int WATCHDOG_LIM  = 20000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 24;
	localparam int EPISODE_LEN   = 28;
	localparam int EPISODES      = 4;

	// unmapped register index, writes to it must change nothing
	localparam logic [W_CFGA-1:0] CFG_SPARE = 2'd3;

	typedef enum logic [W_DIR-1:0] {
		FACE_FRONT  = 3'd0,
		FACE_LEFT   = 3'd1,
		FACE_RIGHT  = 3'd2,
		FACE_BACK   = 3'd3,
		FACE_TOP    = 3'd4,
		FACE_BOTTOM = 3'd5
	} face_t;

	logic clk = 1'b0;
	logic arst_n;

	vfcm_item_if item_ch ();
	vfcm_res_if  res_ch ();
	vfcm_cfg_if  cfg_ch ();

	voxel_face_culling_mesher_top #(
		.MAX_DIM (GRID_MAX)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the block: store contents ({occ, R, G, B, A}) and dims
	// ------------------------------------------------------------------
	logic [32:0]      voxel_mem [STORE_SLOTS];
	logic [W_DIM-1:0] dim_x;
	logic [W_DIM-1:0] dim_y;
	logic [W_DIM-1:0] dim_z;

	// records still owed by the block, oldest first
	res_t pending_records [$];

	int mismatches    = 0;
	int requests_sent = 0;
	int dim_writes    = 0;
	int acks_seen     = 0;
	int faces_seen    = 0;
	int nofaces_seen  = 0;
	int errors_seen   = 0;
	int quiet_cycles  = 0;

	// idling: sender side is read only by the sending process, receiver
	// side is changed with NBAs as the ready driver lives elsewhere
	int   send_idle_pct = 0;
	int   sink_idle_pct = 0;
	logic stall_rx      = 1'b0;

	// corner of the current random cluster
	int org_x;
	int org_y;
	int org_z;

	// oversized dims clip to the grid
	function automatic int clip_dim(input logic [W_DIM-1:0] d);
		return (d > GRID_MAX) ? GRID_MAX : int'(d);
	endfunction

	function automatic bit within_grid(input int x, input int y, input int z);
		return x >= 0 && y >= 0 && z >= 0 &&
			x < clip_dim(dim_x) && y < clip_dim(dim_y) && z < clip_dim(dim_z);
	endfunction

	// raw addressing, independent of the dims in use
	function automatic int store_slot(input int x, input int y, input int z);
		return x + GRID_MAX * (y + GRID_MAX * z);
	endfunction

	// anything off the grid counts as empty
	function automatic bit is_solid(input int x, input int y, input int z);
		if (!within_grid(x, y, z))
			return 1'b0;
		return voxel_mem[store_slot(x, y, z)][32];
	endfunction

	// Works out what one accepted request produces and queues it; also
	// applies writes to the shadow store.
	function automatic void compute_records(input item_t req);
		int          x;
		int          y;
		int          z;
		int          nx;
		int          ny;
		int          nz;
		int          faces;
		bit          ok;
		face_t       dir;
		logic [31:0] rgba;
		res_t        rec;

		x     = int'(req.pos_x);
		y     = int'(req.pos_y);
		z     = int'(req.pos_z);
		ok    = within_grid(x, y, z);
		faces = 0;
		rec   = '0;
		rec.face_x   = req.pos_x;
		rec.face_y   = req.pos_y;
		rec.face_z   = req.pos_z;
		rec.face_dir = DIR_NONE;

		if (req.opcode == OP_WRITE) begin
			if (ok)
				voxel_mem[store_slot(x, y, z)] =
					{req.occupied, req.red, req.green, req.blue, req.alpha};
			rec.kind  = KIND_ACK;
			rec.error = !ok;
			rec.last  = 1'b1;
			pending_records.push_back(rec);
			return;
		end

		if (ok && is_solid(x, y, z)) begin
			rgba = voxel_mem[store_slot(x, y, z)][31:0];
			for (int d = 0; d < N_FACE; d++) begin
				dir = face_t'(d);
				nx  = x;
				ny  = y;
				nz  = z;
				case (dir)
					FACE_FRONT:  nz = z - 1;
					FACE_LEFT:   nx = x - 1;
					FACE_RIGHT:  nx = x + 1;
					FACE_BACK:   nz = z + 1;
					FACE_TOP:    ny = y - 1;
					default:     ny = y + 1;
				endcase
				if (!is_solid(nx, ny, nz)) begin
					rec.kind     = KIND_FACE;
					rec.error    = 1'b0;
					rec.face_dir = dir;
					{rec.red, rec.green, rec.blue, rec.alpha} = rgba;
					rec.last     = 1'b0;
					pending_records.push_back(rec);
					faces++;
				end
			end
		end

		if (faces == 0) begin
			// empty, enclosed or off-grid voxel
			rec.kind     = KIND_NOFACE;
			rec.error    = !ok;
			rec.face_dir = DIR_NONE;
			{rec.red, rec.green, rec.blue, rec.alpha} = '0;
			rec.last     = 1'b1;
			pending_records.push_back(rec);
		end else begin
			rec      = pending_records.pop_back();
			rec.last = 1'b1;
			pending_records.push_back(rec);
		end
	endfunction

	function automatic string show_record(input res_t r);
		return $sformatf("k%0d e%0b (%0d,%0d,%0d) d%0d rgba %h%h%h%h l%0b",
			r.kind, r.error, r.face_x, r.face_y, r.face_z, r.face_dir,
			r.red, r.green, r.blue, r.alpha, r.last);
	endfunction

	// print is capped so a broken block cannot flood the log
	task automatic report_mismatch(input string what, input res_t got, input res_t want);
		mismatches++;
		if (mismatches <= 30)
			$display("[%0t] %s: got %s / expected %s", $time, what,
				show_record(got), show_record(want));
	endtask

	// ------------------------------------------------------------------
	// Result side: random ready plus the record check, one process
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;

		res_ch.ready <= !stall_rx && ($urandom_range(99) >= sink_idle_pct);
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.kind     = kind_t'(res_ch.kind);
			got.error    = res_ch.error;
			got.face_x   = res_ch.face_x;
			got.face_y   = res_ch.face_y;
			got.face_z   = res_ch.face_z;
			got.face_dir = res_ch.face_dir;
			got.red      = res_ch.red_out;
			got.green    = res_ch.green_out;
			got.blue     = res_ch.blue_out;
			got.alpha    = res_ch.alpha_out;
			got.last     = res_ch.last;
			case (got.kind)
				KIND_ACK:  acks_seen++;
				KIND_FACE: faces_seen++;
				default:   nofaces_seen++;
			endcase
			if (got.error === 1'b1)
				errors_seen++;
			if (pending_records.size() == 0) begin
				report_mismatch("result with nothing owed", got, '0);
			end else begin
				want = pending_records.pop_front();
				if (got !== want)
					report_mismatch("record differs", got, want);
			end
		end
	end

	// Progress watchdog: any request on any channel resets the count.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIM) begin
			$display("watchdog: no request moved for %0d cycles", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offers one item and returns at the edge where it is taken. valid is
	// left high; the next call or wait_drained decides what it does next.
	task automatic send_request(input item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid    <= 1'b1;
		item_ch.opcode   <= req.opcode;
		item_ch.pos_x    <= req.pos_x;
		item_ch.pos_y    <= req.pos_y;
		item_ch.pos_z    <= req.pos_z;
		item_ch.occupied <= req.occupied;
		item_ch.red_in   <= req.red;
		item_ch.green_in <= req.green;
		item_ch.blue_in  <= req.blue;
		item_ch.alpha_in <= req.alpha;
		do
			@(posedge clk);
		while (item_ch.ready !== 1'b1);
		compute_records(req);
		requests_sent++;
	endtask

	// Same shape as send_request: valid stays up across back-to-back writes.
	task automatic write_register(input logic [W_CFGA-1:0] idx, input logic [W_DIM-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_DIM_X: dim_x = val;
			CFG_DIM_Y: dim_y = val;
			CFG_DIM_Z: dim_z = val;
			default:   ;
		endcase
		dim_writes++;
	endtask

	task automatic set_grid(input logic [W_DIM-1:0] sx, input logic [W_DIM-1:0] sy,
			input logic [W_DIM-1:0] sz);
		write_register(CFG_DIM_X, sx);
		write_register(CFG_DIM_Y, sy);
		write_register(CFG_DIM_Z, sz);
		cfg_ch.valid <= 1'b0;
	endtask

	// Block is idle once the last owed record has been taken.
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
	endtask

	function automatic item_t make_item(input logic op, input int x, input int y, input int z,
			input logic occ, input logic [31:0] rgba);
		item_t req;
		req.opcode   = op;
		req.pos_x    = W_POS'(x);
		req.pos_y    = W_POS'(y);
		req.pos_z    = W_POS'(z);
		req.occupied = occ;
		{req.red, req.green, req.blue, req.alpha} = rgba;
		return req;
	endfunction

	function automatic void pick_origin();
		org_x = $urandom_range(clip_dim(dim_x) > 0 ? clip_dim(dim_x) - 1 : 0);
		org_y = $urandom_range(clip_dim(dim_y) > 0 ? clip_dim(dim_y) - 1 : 0);
		org_z = $urandom_range(clip_dim(dim_z) > 0 ? clip_dim(dim_z) - 1 : 0);
	endfunction

	// Mostly a 3x3x3 cluster from the origin corner so neighbours really touch;
	// one in ten is fully random noise over the whole field range.
	function automatic item_t random_item(input int write_pct);
		item_t req;
		req.opcode   = 1'($urandom_range(1));
		req.pos_x    = W_POS'($urandom_range(15));
		req.pos_y    = W_POS'($urandom_range(15));
		req.pos_z    = W_POS'($urandom_range(15));
		req.occupied = 1'($urandom_range(1));
		req.red      = W_COL'($urandom_range(255));
		req.green    = W_COL'($urandom_range(255));
		req.blue     = W_COL'($urandom_range(255));
		req.alpha    = W_COL'($urandom_range(255));
		if ($urandom_range(99) >= 10) begin
			req.opcode   = ($urandom_range(99) < write_pct) ? OP_WRITE : OP_MESH;
			req.pos_x    = W_POS'(org_x + $urandom_range(2));
			req.pos_y    = W_POS'(org_y + $urandom_range(2));
			req.pos_z    = W_POS'(org_z + $urandom_range(2));
			req.occupied = ($urandom_range(99) < 85);
		end
		return req;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// never-written voxel, lone voxels at both corners with extreme colours
	task automatic test_empty_and_single();
		set_grid(5'd16, 5'd16, 5'd16);
		send_request(make_item(OP_MESH, 0, 0, 0, 1'b0, 32'h0));
		send_request(make_item(OP_WRITE, 0, 0, 0, 1'b1, 32'hFFFF_FFFF));
		send_request(make_item(OP_MESH, 0, 0, 0, 1'b0, 32'h0));
		send_request(make_item(OP_WRITE, 15, 15, 15, 1'b1, 32'h0));
		send_request(make_item(OP_MESH, 15, 15, 15, 1'b0, 32'hFFFF_FFFF));
		wait_drained();
	endtask

	// fully enclosed voxel, a neighbour with one hidden face, then an empty
	// write that opens one face back up
	task automatic test_enclosure();
		send_request(make_item(OP_WRITE, 5, 5, 5, 1'b1, 32'h1234_5678));
		send_request(make_item(OP_WRITE, 5, 5, 4, 1'b1, 32'hA5A5_5A5A));
		send_request(make_item(OP_WRITE, 4, 5, 5, 1'b1, 32'h0102_0304));
		send_request(make_item(OP_WRITE, 6, 5, 5, 1'b1, 32'h0506_0708));
		send_request(make_item(OP_WRITE, 5, 5, 6, 1'b1, 32'h090A_0B0C));
		send_request(make_item(OP_WRITE, 5, 4, 5, 1'b1, 32'h0D0E_0F10));
		send_request(make_item(OP_WRITE, 5, 6, 5, 1'b1, 32'h1112_1314));
		send_request(make_item(OP_MESH, 5, 5, 5, 1'b0, 32'h0));
		send_request(make_item(OP_MESH, 5, 5, 4, 1'b0, 32'h0));
		send_request(make_item(OP_WRITE, 5, 5, 6, 1'b0, 32'hAAAA_AAAA));
		send_request(make_item(OP_MESH, 5, 5, 5, 1'b0, 32'h0));
		send_request(make_item(OP_MESH, 5, 5, 6, 1'b0, 32'h0));
		wait_drained();
	endtask

	// 1x1x1 grid, zero grid, oversized grid; stored voxels hide and return
	task automatic test_grid_limits();
		set_grid(5'd1, 5'd1, 5'd1);
		send_request(make_item(OP_WRITE, 1, 0, 0, 1'b1, 32'hDEAD_BEEF));
		send_request(make_item(OP_MESH, 0, 0, 0, 1'b0, 32'h0));
		send_request(make_item(OP_MESH, 5, 5, 5, 1'b0, 32'h0));
		wait_drained();

		write_register(CFG_SPARE, 5'd9);
		set_grid(5'd0, 5'd0, 5'd0);
		send_request(make_item(OP_WRITE, 0, 0, 0, 1'b0, 32'h0));
		send_request(make_item(OP_MESH, 0, 0, 0, 1'b0, 32'h0));
		wait_drained();

		set_grid(5'd31, 5'd17, 5'd16);
		send_request(make_item(OP_MESH, 15, 15, 15, 1'b0, 32'h0));
		send_request(make_item(OP_MESH, 5, 5, 5, 1'b0, 32'h0));
		wait_drained();
	endtask

	// Each episode builds up a cluster with mostly writes, then meshes it.
	task automatic test_random_traffic(input int sidle, input int ridle,
			input logic [W_DIM-1:0] sx, input logic [W_DIM-1:0] sy,
			input logic [W_DIM-1:0] sz);
		send_idle_pct = sidle;
		sink_idle_pct <= ridle;
		set_grid(sx, sy, sz);
		for (int ep = 0; ep < EPISODES; ep++) begin
			pick_origin();
			for (int i = 0; i < EPISODE_LEN; i++)
				send_request(random_item(i < EPISODE_LEN * 3 / 5 ? 80 : 20));
		end
		wait_drained();
	endtask

	// Receiver holds off for a long stretch while items keep coming, so the
	// result register fills and the item port has to stall.
	task automatic test_backpressure();
		send_idle_pct = 0;
		sink_idle_pct <= 0;
		pick_origin();
		fork
			begin
				stall_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_rx <= 1'b0;
			end
			for (int i = 0; i < 16; i++)
				send_request(random_item(30));
		join
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		res_t none;

		none = '0;
		for (int i = 0; i < STORE_SLOTS; i++)
			voxel_mem[i] = '0;
		dim_x = DIM_RESET;
		dim_y = DIM_RESET;
		dim_z = DIM_RESET;

		// item and config inputs known from time zero; result ready is
		// driven by the checker from the first edge
		arst_n           <= 1'b0;
		item_ch.valid    <= 1'b0;
		item_ch.opcode   <= OP_WRITE;
		item_ch.pos_x    <= '0;
		item_ch.pos_y    <= '0;
		item_ch.pos_z    <= '0;
		item_ch.occupied <= 1'b0;
		item_ch.red_in   <= '0;
		item_ch.green_in <= '0;
		item_ch.blue_in  <= '0;
		item_ch.alpha_in <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.addr      <= CFG_DIM_X;
		cfg_ch.data      <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under light sender / heavy receiver idling
		send_idle_pct = 7;
		sink_idle_pct <= 73;
		test_empty_and_single();
		test_enclosure();
		test_grid_limits();

		test_random_traffic(7, 73, 5'd16, 5'd16, 5'd16);
		test_random_traffic(73, 7, 5'd5, 5'd3, 5'd7);
		test_random_traffic(0, 0, 5'd31, 5'd12, 5'd17);
		test_backpressure();

		// anything turning up now is a stray record
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (pending_records.size() > 0)
			report_mismatch("record never arrived", none, pending_records.pop_front());

		$display("run covered %0d item requests and %0d register writes, incl. zero,",
			requests_sent, dim_writes);
		$display("oversized and tiny grids and a %0d-cycle result stall; %s",
			HOLD_CYCLES, $sformatf("checked %0d acks, %0d faces, %0d no-face, %0d off-grid",
			acks_seen, faces_seen, nofaces_seen, errors_seen));
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
